@@ rtl/core/keyed_batch_round_robin_queue_assert.svh @@
// Assertion macros for the keyed batch round-robin queue.
// Used by the RTL in this folder; the macros expand to nothing under SYNTHESIS.
`ifndef KEYED_BATCH_ROUND_ROBIN_QUEUE_ASSERT_SVH
`define KEYED_BATCH_ROUND_ROBIN_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled during reset.
`define KBRQ_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, clocked on clk and disabled during reset.
`define KBRQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define KBRQ_ASSERT(lbl, pre, post, msg)
`define KBRQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/core/kbrq_pkg.sv @@
// Shared types and constants of the keyed batch round-robin queue.
// No dependencies; used by kbrq_evstore and the top level.
`default_nettype none
package kbrq_pkg;

  localparam int KEY_BITS    = 16;
  localparam int HANDLE_BITS = 32;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_FLUSHED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_GIVEN   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic [2:0] CFG_MAIN_RUN  = 3'd0;
  localparam logic [2:0] CFG_SUB_RUN   = 3'd1;
  localparam logic [2:0] CFG_ACTIVE    = 3'd2;
  localparam logic [2:0] CFG_THRESH    = 3'd3;
  localparam logic [2:0] CFG_FLUSH_DIS = 3'd4;

  localparam logic [7:0] MAIN_RUN_RST = 8'd3;
  localparam logic [7:0] SUB_RUN_RST  = 8'd1;
  localparam logic [5:0] ACTIVE_RST   = 6'd4;
  localparam logic [7:0] THRESH_RST   = 8'd200;

  typedef struct packed {
    logic                   kind;
    logic [KEY_BITS-1:0]    batch_key;
    logic [HANDLE_BITS-1:0] event_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [KEY_BITS-1:0]    out_key;
    logic [8:0]             flushed_count;
    logic [8:0]             queued_count;
  } out_item_t;

  // Commands from the sequencer to the event store.
  typedef struct packed {
    logic alloc;
    logic rel;
    logic flush;
    logic link_we;
  } ev_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/keyed_batch_round_robin_queue.sv @@
// Channel  Signals                          Direction
// input    in_valid/in_ready/in_data        in  (enqueue or dequeue request)
// result   out_valid/out_ready/out_data     out (one result per item)
// config   cfg_we/cfg_addr/cfg_wdata        in  (write only)
// One item at a time. An enqueue steps through S_E_SRCH, S_E_ALLOC and S_DONE,
// the last of them the output state, before the next accept.
// A dequeue runs path passes through S_D_PASS, the path states, S_POP and
// S_GIVE when an event is found, and S_SCHED, plus a step for each batch moved
// between lists; the event memory read is registered. Reset is synchronous;
// no clearing pass is needed. A full output register stalls the sequencer only in S_DONE.
`default_nettype none
`include "keyed_batch_round_robin_queue_assert.svh"
module keyed_batch_round_robin_queue #(
  parameter int EVENT_SLOTS = 256,
  parameter int BATCH_SLOTS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire kbrq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output kbrq_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_addr,
  input  wire logic [7:0]          cfg_wdata
);

  localparam int EW  = $clog2(EVENT_SLOTS);
  localparam int CW  = $clog2(EVENT_SLOTS + 1);
  localparam int BW  = $clog2(BATCH_SLOTS);
  localparam int LW  = $clog2(BATCH_SLOTS + 1);
  localparam int KB  = kbrq_pkg::KEY_BITS;
  localparam int HB  = kbrq_pkg::HANDLE_BITS;
  localparam int HKW = KB + HB;
  localparam int NL  = 3;
  localparam int L_COMMON = 0;
  localparam int L_BONLY  = 1;
  localparam int L_SUB    = 2;
  localparam logic [2:0] PASS_MAX = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_E_SRCH, S_E_ALLOC, S_D_PASS, S_M_START, S_M_LOOP,
    S_POP, S_GIVE, S_SCHED, S_S_FILL, S_S_SERVE, S_DONE
  } state_t;

  typedef enum logic [1:0] {SRC_MAINQ, SRC_MBATCH, SRC_SBATCH} src_t;

  state_t state_r;
  src_t   src_r;

  logic [7:0] mrl_r, srl_r, thr_r;
  logic [5:0] abl_r;
  logic       fdis_r;

  kbrq_pkg::in_item_t  item_r;
  kbrq_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic [2:0]          st_r;
  logic [CW-1:0]       flushed_r;
  logic [HB-1:0]       oh_r;
  logic [KB-1:0]       ok_r;
  logic                got_r, pgot_r;
  logic [2:0]          pass_r;
  logic                feed_main_r;
  logic [7:0]          mrun_r, srun_r;
  logic [BW-1:0]       b_r;
  logic [EW-1:0]       e_r;
  logic                found_r, can_r;
  logic [CW-1:0]       total_r;

  logic [BATCH_SLOTS-1:0] bt_valid_r;
  logic [KB-1:0]          bt_key_r  [BATCH_SLOTS];
  logic [EW-1:0]          bt_head_r [BATCH_SLOTS];
  logic [EW-1:0]          bt_tail_r [BATCH_SLOTS];
  logic [CW-1:0]          bt_cnt_r  [BATCH_SLOTS];
  logic [BW-1:0]          blink_r   [BATCH_SLOTS];

  logic [BW-1:0] lh_r [NL];
  logic [BW-1:0] lt_r [NL];
  logic [LW-1:0] lc_r [NL];

  logic [EW-1:0] mq_head_r, mq_tail_r;
  logic [CW-1:0] mq_cnt_r;

  kbrq_pkg::ev_ctl_t ctl;
  logic [EW-1:0]     lk_wa, lk_wd, rd_addr, alloc_slot, lk_rd;
  logic [HKW-1:0]    hk_rd;
  logic [NL-1:0]     pop_en, push_en;
  logic [BW-1:0]     push_b;

  logic          hit, fre;
  logic [BW-1:0] hit_idx, fre_idx;
  logic [BW-1:0] b_com, b_bo, b_sub;
  logic [5:0]    act_lim;
  logic [7:0]    mlim, slim;
  logic          fill_go, com_single, in_acc, do_flush, store_full;
  logic [CW-1:0] ncnt_b;

  kbrq_evstore #(.EVENT_SLOTS(EVENT_SLOTS)) u_evstore (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rel_slot  (e_r),
    .lk_wa     (lk_wa),
    .lk_wd     (lk_wd),
    .rd_addr   (rd_addr),
    .hk_wd     ({item_r.batch_key, item_r.event_handle}),
    .alloc_slot(alloc_slot),
    .lk_rd     (lk_rd),
    .hk_rd     (hk_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign b_com      = lh_r[L_COMMON];
  assign b_bo       = lh_r[L_BONLY];
  assign b_sub      = lh_r[L_SUB];
  assign act_lim    = (abl_r == '0) ? 6'd1 : abl_r;
  assign mlim       = (mrl_r == '0) ? 8'd1 : mrl_r;
  assign slim       = (srl_r == '0) ? 8'd1 : srl_r;
  assign fill_go    = (32'(lc_r[L_SUB]) < 32'(act_lim)) &&
                      ((lc_r[L_BONLY] != '0) || (lc_r[L_COMMON] != '0));
  assign com_single = (bt_cnt_r[b_com] < CW'(2)) || (bt_key_r[b_com] == '0);
  assign in_acc     = in_valid && in_ready;
  assign do_flush   = in_acc && (in_data.kind == kbrq_pkg::KIND_ENQ) && !fdis_r &&
                      (32'(total_r) > 32'(thr_r));
  assign store_full = (32'(total_r) == EVENT_SLOTS);
  assign ncnt_b     = bt_cnt_r[b_r] - CW'(1);

  // Key lookup over the batch table; the lowest matching or free index wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    fre     = 1'b0;
    fre_idx = '0;
    for (int i = BATCH_SLOTS - 1; i >= 0; i--) begin
      if (bt_valid_r[i] && (bt_key_r[i] == item_r.batch_key)) begin
        hit     = 1'b1;
        hit_idx = BW'(i);
      end
      if (!bt_valid_r[i]) begin
        fre     = 1'b1;
        fre_idx = BW'(i);
      end
    end
  end

  // Memory commands and list pushes/pops for the current step.
  always_comb begin
    ctl         = '0;
    ctl.flush   = do_flush;
    lk_wa       = mq_tail_r;
    lk_wd       = '0;
    rd_addr     = mq_head_r;
    pop_en      = '0;
    push_en     = '0;
    push_b      = b_com;
    case (state_r)
      S_E_ALLOC: begin
        if (!store_full && can_r) begin
          ctl.alloc = 1'b1;
          if (!found_r) begin
            push_en[L_COMMON] = 1'b1;
            push_b            = b_r;
          end else if (bt_cnt_r[b_r] != '0) begin
            ctl.link_we = 1'b1;
            lk_wa       = bt_tail_r[b_r];
            lk_wd       = alloc_slot;
          end
        end
      end
      S_M_LOOP: begin
        rd_addr = bt_head_r[b_com];
        if (lc_r[L_COMMON] != '0) begin
          pop_en[L_COMMON] = 1'b1;
          if (!com_single) begin
            push_en[L_BONLY] = 1'b1;
          end
        end
      end
      S_POP: begin
        // The rest of a served main batch joins the main FIFO.
        if (src_r == SRC_MBATCH && ncnt_b != '0 && mq_cnt_r != '0) begin
          ctl.link_we = 1'b1;
          lk_wd       = lk_rd;
        end
        if (src_r == SRC_SBATCH && ncnt_b != '0) begin
          push_en[L_SUB] = 1'b1;
          push_b         = b_r;
        end
      end
      S_GIVE: begin
        ctl.rel = 1'b1;
      end
      S_S_FILL: begin
        if (fill_go) begin
          if (lc_r[L_BONLY] != '0) begin
            pop_en[L_BONLY] = 1'b1;
            push_en[L_SUB]  = 1'b1;
            push_b          = b_bo;
          end else begin
            pop_en[L_COMMON] = 1'b1;
            if (!com_single) begin
              push_en[L_SUB] = 1'b1;
            end else if (bt_cnt_r[b_com] != '0 && mq_cnt_r != '0) begin
              ctl.link_we = 1'b1;
              lk_wd       = bt_head_r[b_com];
            end
          end
        end
      end
      S_S_SERVE: begin
        rd_addr = bt_head_r[b_sub];
        if (lc_r[L_SUB] != '0) begin
          pop_en[L_SUB] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Batch lists: common (creation order), batch-only and round-robin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NL; l++) begin
        lc_r[l] <= '0;
      end
    end else if (ctl.flush) begin
      for (int l = 0; l < NL; l++) begin
        lc_r[l] <= '0;
      end
    end else begin
      for (int l = 0; l < NL; l++) begin
        if (pop_en[l]) begin
          lh_r[l] <= blink_r[lh_r[l]];
        end
        if (push_en[l]) begin
          if (lc_r[l] == '0) begin
            lh_r[l] <= push_b;
          end else begin
            blink_r[lt_r[l]] <= push_b;
          end
          lt_r[l] <= push_b;
        end
        lc_r[l] <= lc_r[l] + LW'(push_en[l]) - LW'(pop_en[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mrl_r       <= kbrq_pkg::MAIN_RUN_RST;
      srl_r       <= kbrq_pkg::SUB_RUN_RST;
      abl_r       <= kbrq_pkg::ACTIVE_RST;
      thr_r       <= kbrq_pkg::THRESH_RST;
      fdis_r      <= 1'b0;
      total_r     <= '0;
      bt_valid_r  <= '0;
      mq_cnt_r    <= '0;
      feed_main_r <= 1'b1;
      mrun_r      <= '0;
      srun_r      <= '0;
      got_r       <= 1'b0;
      pgot_r      <= 1'b0;
      pass_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          kbrq_pkg::CFG_MAIN_RUN:  mrl_r  <= cfg_wdata;
          kbrq_pkg::CFG_SUB_RUN:   srl_r  <= cfg_wdata;
          kbrq_pkg::CFG_ACTIVE:    abl_r  <= cfg_wdata[5:0];
          kbrq_pkg::CFG_THRESH:    thr_r  <= cfg_wdata;
          kbrq_pkg::CFG_FLUSH_DIS: fdis_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            item_r    <= in_data;
            oh_r      <= '0;
            ok_r      <= '0;
            got_r     <= 1'b0;
            pass_r    <= '0;
            flushed_r <= do_flush ? total_r : '0;
            st_r      <= do_flush ? kbrq_pkg::ST_FLUSHED : kbrq_pkg::ST_QUEUED;
            if (in_data.kind == kbrq_pkg::KIND_ENQ) begin
              state_r <= S_E_SRCH;
              if (do_flush) begin
                total_r    <= '0;
                bt_valid_r <= '0;
                mq_cnt_r   <= '0;
              end
            end else begin
              state_r <= S_D_PASS;
            end
          end
        end
        S_E_SRCH: begin
          b_r     <= hit ? hit_idx : fre_idx;
          found_r <= hit;
          can_r   <= hit || fre;
          state_r <= S_E_ALLOC;
        end
        S_E_ALLOC: begin
          if (store_full || !can_r) begin
            st_r <= kbrq_pkg::ST_FULL;
          end else begin
            if (!found_r) begin
              bt_valid_r[b_r] <= 1'b1;
              bt_key_r[b_r]   <= item_r.batch_key;
            end
            if (!found_r || bt_cnt_r[b_r] == '0) begin
              bt_head_r[b_r] <= alloc_slot;
            end
            bt_tail_r[b_r] <= alloc_slot;
            bt_cnt_r[b_r]  <= (found_r ? bt_cnt_r[b_r] : '0) + CW'(1);
            total_r        <= total_r + CW'(1);
          end
          state_r <= S_DONE;
        end
        S_D_PASS: begin
          if (got_r || pass_r == PASS_MAX || total_r == '0) begin
            st_r    <= got_r ? kbrq_pkg::ST_GIVEN : kbrq_pkg::ST_EMPTY;
            state_r <= S_DONE;
          end else begin
            state_r <= feed_main_r ? S_M_START : S_S_FILL;
          end
        end
        S_M_START: begin
          if (mq_cnt_r != '0) begin
            e_r     <= mq_head_r;
            src_r   <= SRC_MAINQ;
            state_r <= S_POP;
          end else begin
            state_r <= S_M_LOOP;
          end
        end
        S_M_LOOP: begin
          if (lc_r[L_COMMON] == '0) begin
            pgot_r  <= 1'b0;
            state_r <= S_SCHED;
          end else if (com_single) begin
            if (bt_cnt_r[b_com] != '0) begin
              b_r     <= b_com;
              e_r     <= bt_head_r[b_com];
              src_r   <= SRC_MBATCH;
              state_r <= S_POP;
            end else begin
              bt_valid_r[b_com] <= 1'b0;
            end
          end
        end
        S_POP: begin
          oh_r <= hk_rd[HB-1:0];
          ok_r <= hk_rd[HKW-1:HB];
          case (src_r)
            SRC_MAINQ: begin
              mq_head_r <= lk_rd;
              mq_cnt_r  <= mq_cnt_r - CW'(1);
            end
            SRC_MBATCH: begin
              bt_cnt_r[b_r]   <= '0;
              bt_valid_r[b_r] <= 1'b0;
              if (ncnt_b != '0) begin
                if (mq_cnt_r == '0) begin
                  mq_head_r <= lk_rd;
                end
                mq_tail_r <= bt_tail_r[b_r];
                mq_cnt_r  <= mq_cnt_r + ncnt_b;
              end
            end
            SRC_SBATCH: begin
              bt_head_r[b_r] <= lk_rd;
              bt_cnt_r[b_r]  <= ncnt_b;
              if (ncnt_b == '0) begin
                bt_valid_r[b_r] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
          state_r <= S_GIVE;
        end
        S_GIVE: begin
          if (total_r != '0) begin
            total_r <= total_r - CW'(1);
          end
          pgot_r  <= 1'b1;
          state_r <= S_SCHED;
        end
        S_SCHED: begin
          got_r  <= pgot_r;
          pass_r <= pass_r + 3'd1;
          if (feed_main_r) begin
            if (!pgot_r || (9'(mrun_r) + 9'd1 >= 9'(mlim))) begin
              feed_main_r <= 1'b0;
              mrun_r      <= '0;
            end else begin
              mrun_r <= mrun_r + 8'd1;
            end
          end else begin
            if (!pgot_r || (9'(srun_r) + 9'd1 >= 9'(slim))) begin
              feed_main_r <= 1'b1;
              srun_r      <= '0;
            end else begin
              srun_r <= srun_r + 8'd1;
            end
          end
          state_r <= S_D_PASS;
        end
        S_S_FILL: begin
          if (fill_go) begin
            // A common batch unfit for round robin spills whole to the main FIFO.
            if (lc_r[L_BONLY] == '0 && com_single) begin
              bt_valid_r[b_com] <= 1'b0;
              bt_cnt_r[b_com]   <= '0;
              if (bt_cnt_r[b_com] != '0) begin
                if (mq_cnt_r == '0) begin
                  mq_head_r <= bt_head_r[b_com];
                end
                mq_tail_r <= bt_tail_r[b_com];
                mq_cnt_r  <= mq_cnt_r + bt_cnt_r[b_com];
              end
            end
          end else begin
            state_r <= S_S_SERVE;
          end
        end
        S_S_SERVE: begin
          if (lc_r[L_SUB] == '0) begin
            pgot_r  <= 1'b0;
            state_r <= S_SCHED;
          end else if (bt_cnt_r[b_sub] == '0) begin
            bt_valid_r[b_sub] <= 1'b0;
            pgot_r            <= 1'b0;
            state_r           <= S_SCHED;
          end else begin
            b_r     <= b_sub;
            e_r     <= bt_head_r[b_sub];
            src_r   <= SRC_SBATCH;
            state_r <= S_POP;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.status        <= st_r;
            out_r.out_handle    <= oh_r;
            out_r.out_key       <= ok_r;
            out_r.flushed_count <= 9'(flushed_r);
            out_r.queued_count  <= 9'(total_r);
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `KBRQ_ASSERT(a_total_cap, 1'b1, 32'(total_r) <= EVENT_SLOTS, "stored count beyond capacity")
  `KBRQ_ASSERT(a_alloc_room, ctl.alloc, !store_full, "slot taken from a full store")
  `KBRQ_ASSERT(a_pass_bound, state_r == S_D_PASS, pass_r <= PASS_MAX, "too many path passes")
  `KBRQ_ASSERT_NEXT(a_got_ends, state_r == S_SCHED && pgot_r, state_r == S_D_PASS && got_r, "given event not carried to pass check")

endmodule
`default_nettype wire

@@ rtl/core/kbrq_evstore.sv @@
// Event store: handle/key memory, link memory and the free-slot allocator.
// Depends on kbrq_pkg.
`default_nettype none
module kbrq_evstore #(
  parameter int EVENT_SLOTS = 256,
  localparam int EW  = $clog2(EVENT_SLOTS),
  localparam int HKW = kbrq_pkg::KEY_BITS + kbrq_pkg::HANDLE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kbrq_pkg::ev_ctl_t ctl,
  input  wire logic [EW-1:0]     rel_slot,
  input  wire logic [EW-1:0]     lk_wa,
  input  wire logic [EW-1:0]     lk_wd,
  input  wire logic [EW-1:0]     rd_addr,
  input  wire logic [HKW-1:0]    hk_wd,
  output logic [EW-1:0]          alloc_slot,
  output logic [EW-1:0]          lk_rd,
  output logic [HKW-1:0]         hk_rd
);

  localparam int CW = $clog2(EVENT_SLOTS + 1);

  logic [EW-1:0]  link_mem [EVENT_SLOTS];
  logic [HKW-1:0] hk_mem   [EVENT_SLOTS];

  // Slots below the watermark have been used; freed ones sit on a stack.
  logic [CW-1:0] wm_r;
  logic [CW-1:0] fc_r;
  logic [EW-1:0] fh_r;
  logic          pend_r;

  logic          lk_we;
  logic [EW-1:0] lk_wa_m;
  logic [EW-1:0] lk_wd_m;
  logic [EW-1:0] lk_ra;

  assign alloc_slot = (fc_r != '0) ? fh_r : wm_r[EW-1:0];
  assign lk_we      = ctl.rel | ctl.link_we;
  assign lk_wa_m    = ctl.rel ? rel_slot : lk_wa;
  assign lk_wd_m    = ctl.rel ? fh_r : lk_wd;
  assign lk_ra      = ctl.alloc ? fh_r : rd_addr;

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_wa_m] <= lk_wd_m;
    end
    lk_rd <= link_mem[lk_ra];
    if (ctl.alloc) begin
      hk_mem[alloc_slot] <= hk_wd;
    end
    hk_rd <= hk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_r   <= '0;
      fc_r   <= '0;
      fh_r   <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= 1'b0;
      if (ctl.flush) begin
        wm_r <= '0;
        fc_r <= '0;
      end else begin
        // The popped slot's link arrives from the registered link read in the following cycle.
        if (pend_r) begin
          fh_r <= lk_rd;
        end
        if (ctl.alloc) begin
          if (fc_r != '0) begin
            fc_r   <= fc_r - CW'(1);
            pend_r <= 1'b1;
          end else begin
            wm_r <= wm_r + CW'(1);
          end
        end
        if (ctl.rel) begin
          fh_r <= rel_slot;
          fc_r <= fc_r + CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for keyed_batch_round_robin_queue.
// Needs kbrq_pkg and the RTL of the block; predicts every result in place.
`timescale 1ns / 1ps
module tb;

  localparam int NSLOT = 256;
  localparam int NBATCH = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {LST_COMMON, LST_BONLY, LST_RR} blist_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  kbrq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kbrq_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = kbrq_pkg::CFG_MAIN_RUN;
  logic [7:0] cfg_wdata = '0;

  keyed_batch_round_robin_queue uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block's registers and storage.
  int main_lim, sub_lim, active_lim, thresh, flush_off;
  logic [31:0] ev_h[NSLOT];
  logic [15:0] ev_k[NSLOT];
  int ev_ln[NSLOT];
  int free_head, free_cnt, total;
  bit bv[NBATCH];
  logic [15:0] bk[NBATCH];
  int bh[NBATCH], bt[NBATCH], bc[NBATCH], bnext[NBATCH];
  int lh[3], lt[3], lc[3];
  int mq_head, mq_tail, mq_cnt;
  bit on_main;
  int main_run, sub_run;

  kbrq_pkg::in_item_t pending[$];
  kbrq_pkg::out_item_t outcome_q[$];
  int fails = 0;
  int cyc = 0;
  int quiet_from = 0, quiet_to = 0;
  bit hold_req = 0, hold_done = 0;
  int hold_left = 0;
  int stall_cnt = 0;

  function automatic void wipe_store();
    for (int i = 0; i < NSLOT; i++) begin
      ev_h[i] = '0;
      ev_k[i] = '0;
      ev_ln[i] = (i + 1) % NSLOT;
    end
    for (int i = 0; i < NBATCH; i++) begin
      bv[i] = 0; bk[i] = '0; bh[i] = 0; bt[i] = 0; bc[i] = 0; bnext[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      lh[i] = 0; lt[i] = 0; lc[i] = 0;
    end
    mq_head = 0; mq_tail = 0; mq_cnt = 0;
    free_head = 0; free_cnt = NSLOT; total = 0;
  endfunction

  function automatic void list_push(blist_t l, int b);
    if (lc[l] == 0) lh[l] = b; else bnext[lt[l]] = b;
    lt[l] = b;
    lc[l]++;
  endfunction

  function automatic int list_pop(blist_t l);
    int b;
    b = lh[l];
    lh[l] = bnext[b];
    lc[l]--;
    return b;
  endfunction

  function automatic void hand_out(int e, output logic [31:0] h, output logic [15:0] k);
    h = ev_h[e];
    k = ev_k[e];
    ev_ln[e] = free_head;
    free_head = e;
    free_cnt++;
    if (total > 0) total--;
  endfunction

  function automatic int batch_take(int b);
    int e;
    e = bh[b];
    bh[b] = ev_ln[e];
    bc[b]--;
    return e;
  endfunction

  // The rest of a batch joins the main FIFO and the batch is dropped.
  function automatic void spill(int b);
    if (bc[b] > 0) begin
      if (mq_cnt == 0) mq_head = bh[b]; else ev_ln[mq_tail] = bh[b];
      mq_tail = bt[b];
      mq_cnt += bc[b];
    end
    bc[b] = 0;
    bv[b] = 0;
  endfunction

  function automatic bit try_main(output logic [31:0] h, output logic [15:0] k);
    int e, b;
    bit got;
    if (mq_cnt > 0) begin
      e = mq_head;
      mq_head = ev_ln[e];
      mq_cnt--;
      hand_out(e, h, k);
      return 1;
    end
    while (lc[LST_COMMON] > 0) begin
      b = list_pop(LST_COMMON);
      if (bc[b] <= 1 || bk[b] == 0) begin
        got = 0;
        if (bc[b] > 0) begin
          e = batch_take(b);
          got = 1;
        end
        spill(b);
        if (got) begin
          hand_out(e, h, k);
          return 1;
        end
      end else begin
        list_push(LST_BONLY, b);
      end
    end
    return 0;
  endfunction

  function automatic bit try_sub(output logic [31:0] h, output logic [15:0] k);
    int lim, b, e;
    lim = (active_lim == 0) ? 1 : active_lim;
    while (lc[LST_RR] < lim && (lc[LST_BONLY] > 0 || lc[LST_COMMON] > 0)) begin
      if (lc[LST_BONLY] > 0) begin
        list_push(LST_RR, list_pop(LST_BONLY));
      end else begin
        b = list_pop(LST_COMMON);
        if (bc[b] > 1 && bk[b] != 0) list_push(LST_RR, b);
        else spill(b);
      end
    end
    if (lc[LST_RR] == 0) return 0;
    b = list_pop(LST_RR);
    if (bc[b] == 0) begin
      bv[b] = 0;
      return 0;
    end
    e = batch_take(b);
    if (bc[b] > 0) list_push(LST_RR, b); else bv[b] = 0;
    hand_out(e, h, k);
    return 1;
  endfunction

  function automatic void queue_outcome(kbrq_pkg::in_item_t it);
    kbrq_pkg::out_item_t r;
    int b, e;
    bit found, slot, got;
    logic [31:0] h;
    logic [15:0] k;
    r = '0;
    found = 0;
    slot = 0;
    got = 0;
    b = 0;
    if (it.kind == kbrq_pkg::KIND_ENQ) begin
      r.status = kbrq_pkg::ST_QUEUED;
      if (!flush_off && total > thresh) begin
        r.flushed_count = 9'(total);
        wipe_store();
        r.status = kbrq_pkg::ST_FLUSHED;
      end
      for (int i = 0; i < NBATCH && !found; i++)
        if (bv[i] && bk[i] == it.batch_key) begin
          b = i;
          found = 1;
        end
      if (!found)
        for (int i = 0; i < NBATCH && !slot; i++)
          if (!bv[i]) begin
            b = i;
            slot = 1;
          end
      if (free_cnt == 0 || (!found && !slot)) begin
        r.status = kbrq_pkg::ST_FULL;
      end else begin
        if (!found) begin
          bv[b] = 1;
          bk[b] = it.batch_key;
          bc[b] = 0;
          list_push(LST_COMMON, b);
        end
        e = free_head;
        free_head = ev_ln[e];
        free_cnt--;
        ev_h[e] = it.event_handle;
        ev_k[e] = it.batch_key;
        if (bc[b] == 0) bh[b] = e; else ev_ln[bt[b]] = e;
        bt[b] = e;
        bc[b]++;
        total++;
      end
    end else begin
      // At most four path passes before giving up.
      for (int pass = 0; pass < 4 && !got && total > 0; pass++) begin
        if (on_main) begin
          got = try_main(h, k);
          if (got) main_run++;
          if (!got || main_run >= main_lim) begin
            on_main = 0;
            main_run = 0;
          end
        end else begin
          got = try_sub(h, k);
          if (got) sub_run++;
          if (!got || sub_run >= sub_lim) begin
            on_main = 1;
            sub_run = 0;
          end
        end
      end
      r.status = got ? kbrq_pkg::ST_GIVEN : kbrq_pkg::ST_EMPTY;
      if (got) begin
        r.out_handle = h;
        r.out_key = k;
      end
    end
    r.queued_count = 9'(total);
    outcome_q.push_back(r);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h, want %0h", cyc, what, got, want);
    fails++;
  endtask

  function automatic bit idle_now();
    return !(cyc >= quiet_from && cyc < quiet_to) && $urandom_range(0, 99) < 12;
  endfunction

  // Sender: each accepted item is predicted at the edge that takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) queue_outcome(in_data);
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && !idle_now()) begin
          in_valid <= 1'b1;
          in_data <= pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        report("unexpected result", 32'd1, 32'd0);
      end else begin
        kbrq_pkg::out_item_t w;
        w = outcome_q.pop_front();
        if (out_data.status !== w.status)
          report("status", 32'(out_data.status), 32'(w.status));
        if (out_data.out_handle !== w.out_handle)
          report("out_handle", out_data.out_handle, w.out_handle);
        if (out_data.out_key !== w.out_key)
          report("out_key", 32'(out_data.out_key), 32'(w.out_key));
        if (out_data.flushed_count !== w.flushed_count)
          report("flushed_count", 32'(out_data.flushed_count), 32'(w.flushed_count));
        if (out_data.queued_count !== w.queued_count)
          report("queued_count", 32'(out_data.queued_count), 32'(w.queued_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      kbrq_pkg::CFG_MAIN_RUN: main_lim = int'(val);
      kbrq_pkg::CFG_SUB_RUN: sub_lim = int'(val);
      kbrq_pkg::CFG_ACTIVE: active_lim = int'(val[5:0]);
      kbrq_pkg::CFG_THRESH: thresh = int'(val);
      kbrq_pkg::CFG_FLUSH_DIS: flush_off = int'(val[0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_all(int m, int s, int a, int t, int f);
    write_reg(kbrq_pkg::CFG_MAIN_RUN, 8'(m));
    write_reg(kbrq_pkg::CFG_SUB_RUN, 8'(s));
    write_reg(kbrq_pkg::CFG_ACTIVE, 8'(a));
    write_reg(kbrq_pkg::CFG_THRESH, 8'(t));
    write_reg(kbrq_pkg::CFG_FLUSH_DIS, 8'(f));
  endtask

  function automatic kbrq_pkg::in_item_t enq(logic [15:0] key, logic [31:0] h);
    kbrq_pkg::in_item_t it;
    it.kind = kbrq_pkg::KIND_ENQ;
    it.batch_key = key;
    it.event_handle = h;
    return it;
  endfunction

  function automatic kbrq_pkg::in_item_t deq();
    kbrq_pkg::in_item_t it;
    it.kind = kbrq_pkg::KIND_DEQ;
    it.batch_key = 16'($urandom);
    it.event_handle = $urandom;
    return it;
  endfunction

  // Keys mostly come from a small pool so that batches grow.
  task automatic add_random(int n, int deq_pct, int key_pool);
    int r;
    logic [15:0] key;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < deq_pct) begin
        pending.push_back(deq());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) key = 16'd0;
        else if (r < 88) key = 16'($urandom_range(1, key_pool));
        else key = 16'($urandom);
        pending.push_back(enq(key, $urandom));
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending.size() > 0 || in_valid || outcome_q.size() > 0);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    main_lim = int'(kbrq_pkg::MAIN_RUN_RST);
    sub_lim = int'(kbrq_pkg::SUB_RUN_RST);
    active_lim = int'(kbrq_pkg::ACTIVE_RST);
    thresh = int'(kbrq_pkg::THRESH_RST);
    flush_off = 0;
    on_main = 1;
    main_run = 0;
    sub_run = 0;
    wipe_store();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty, extremes, single and multi-event batches, key 0 spill.
    pending.push_back(deq());
    pending.push_back(enq(16'h0000, 32'h0000_0000));
    pending.push_back(enq(16'h0000, 32'hFFFF_FFFF));
    pending.push_back(enq(16'hFFFF, 32'h1234_5678));
    pending.push_back(enq(16'h0001, 32'hA5A5_A5A5));
    pending.push_back(enq(16'h0001, 32'h5A5A_5A5A));
    pending.push_back(enq(16'h0001, 32'h0F0F_0F0F));
    pending.push_back(enq(16'h0002, 32'hF0F0_F0F0));
    pending.push_back(enq(16'h0002, 32'h0000_0001));
    pending.push_back(enq(16'h0003, 32'h8000_0000));
    for (int i = 0; i < 12; i++) pending.push_back(deq());
    drain();
    add_random(280, 45, 10);
    drain();

    // Main run limit of one, long sub runs, one active batch, high threshold.
    set_all(1, 255, 1, 254, 0);
    add_random(250, 40, 12);
    drain();

    // Threshold zero flushes on nearly every enqueue.
    set_all(255, 1, 32, 0, 0);
    add_random(200, 35, 6);
    drain();

    // Zero limits and no flush: fill the store, then hit the batch table limit.
    set_all(0, 0, 0, 100, 1);
    for (int i = 0; i < 258; i++) pending.push_back(enq(16'd0, $urandom));
    drain();
    add_random(40, 95, 6);
    for (int i = 1; i <= 34; i++) pending.push_back(enq(16'(i), $urandom));
    drain();
    add_random(250, 50, 40);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    set_all(2, 3, 5, 60, 0);
    quiet_from = cyc + 50;
    quiet_to = cyc + 3000;
    hold_req = 1;
    add_random(300, 45, 16);
    drain();

    set_all($urandom_range(1, 255), $urandom_range(1, 8), $urandom_range(1, 32),
            $urandom_range(0, 254), 0);
    add_random(250, 45, 20);
    drain();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
